// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition must never be true.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/nfa_pkg.sv
// Package for the next-fit free-block allocator.
// Holds the word types, item kind and status codes, and sequencer states.
`default_nettype none

package nfa_pkg;

    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int FIELD_W   = 16;
    localparam int RESULT_CAP = 32;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DUMP  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ENTRY = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] block_address;
        logic [FIELD_W-1:0] block_size;
        logic [FIELD_W-1:0] request_size;
    } t_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  out_address;
        logic [FIELD_W-1:0]  out_size;
        logic                last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_LINK,
        S_WALK,
        S_DUMP
    } t_state;

endpackage

`default_nettype wire

// File: rtl/next_fit_free_block_allocator.sv
// Top level of the next-fit free-block allocator: sequencer, block table memories.
// Depends on nfa_pkg (types, codes, states) and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Usage
//   Input word: i_item (kind, block_address, block_size, request_size) is taken at a
//   rising edge with i_start high and o_busy low. o_busy stays high while an item is
//   being worked on. Result words appear on o_result for exactly one cycle, marked by
//   o_strobe; o_result.last flags the final word of an item. The receiver cannot stall.
// Sequencing (result words are registered and show in the cycle after the deciding cycle)
//   Add: a free-slot scan visits one slot of the occupancy map per cycle from slot 0,
//     then the new entry is written and linked in; an add into an empty table needs
//     no link step, and a full table is answered from the idle state with no scan.
//   Allocate: the walk reads one linked table entry per cycle through the single read
//     port of the table memories, from the cursor entry until a fit or the list end.
//   Dump: cursor entry read first, then one word per cycle, min(block count, 32) words.
//   Empty table, unused kind: one word, answered from the idle state.
// Reset
//   Synchronous, active low: the table empties, cursor returns to slot 0, all slots
//   are free. Table contents are not cleared; read data is used only from written entries.
module next_fit_free_block_allocator #(
    parameter int MAX_BLOCKS = 32,
    parameter int ADDR_BITS  = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  nfa_pkg::t_item    i_item,
    output logic              o_busy,
    output logic              o_strobe,
    output nfa_pkg::t_result  o_result
);

    localparam int FW = nfa_pkg::FIELD_W;
    localparam int SW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = (ADDR_BITS < FW) ? ADDR_BITS : FW;

    // Block table: one entry per slot, one write per memory and one shared read
    // address per cycle, read data registered.
    logic [AW-1:0] mem_addr [0:MAX_BLOCKS-1];
    logic [FW-1:0] mem_size [0:MAX_BLOCKS-1];
    logic [SW-1:0] mem_link [0:MAX_BLOCKS-1];

    logic [AW-1:0] r_rd_addr;
    logic [FW-1:0] r_rd_size;
    logic [SW-1:0] r_rd_link;

    logic          rd_slot_en;
    logic [SW-1:0] rd_slot;
    logic          wr_addr_en;
    logic          wr_size_en;
    logic          wr_link_en;
    logic [SW-1:0] wr_addr_slot;
    logic [SW-1:0] wr_size_slot;
    logic [SW-1:0] wr_link_slot;
    logic [AW-1:0] wr_addr_data;
    logic [FW-1:0] wr_size_data;
    logic [SW-1:0] wr_link_data;

    // Sequencer and list state
    nfa_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [SW-1:0]    r_cursor, n_cursor;
    logic [SW-1:0]    r_pred, n_pred;
    logic [MAX_BLOCKS-1:0] r_free, n_free;
    logic [SW-1:0]    r_cur, n_cur;
    logic [SW-1:0]    r_prev, n_prev;
    logic [SW-1:0]    r_scan, n_scan;
    logic [CW-1:0]    r_k, n_k;
    nfa_pkg::t_item   r_item, n_item;
    nfa_pkg::t_result r_result, n_result;
    logic             r_strobe, n_strobe;

    logic          accept;
    logic          table_full;
    logic          table_empty;
    logic [CW-1:0] k_inc;
    logic          walk_end;
    logic          dump_last;
    logic          fit;
    logic          exact;
    logic [FW-1:0] remain;
    logic [AW-1:0] in_addr_m;
    logic [AW-1:0] held_addr_m;

    function automatic nfa_pkg::t_result make_result(
        input logic [nfa_pkg::STATUS_W-1:0] status,
        input logic [FW-1:0]                addr,
        input logic [FW-1:0]                size,
        input logic                         last
    );
        nfa_pkg::t_result res;
        res.status      = status;
        res.out_address = addr;
        res.out_size    = size;
        res.last        = last;
        return res;
    endfunction

    assign o_busy      = (r_state != nfa_pkg::S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_result    = r_result;
    assign accept      = i_start && !o_busy;
    assign table_full  = (r_count == CW'(MAX_BLOCKS));
    assign table_empty = (r_count == '0);
    assign k_inc       = r_k + CW'(1);
    assign walk_end    = (k_inc == r_count);
    assign dump_last   = (k_inc == r_count) || (int'(k_inc) == nfa_pkg::RESULT_CAP);
    assign fit         = (r_rd_size >= r_item.request_size);
    assign exact       = (r_rd_size == r_item.request_size);
    assign remain      = r_rd_size - r_item.request_size;
    assign in_addr_m   = i_item.block_address[AW-1:0];
    assign held_addr_m = r_item.block_address[AW-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nfa_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_item.kind)
                        nfa_pkg::KIND_ADD: begin
                            if (!table_full) n_state = nfa_pkg::S_FIND;
                        end
                        nfa_pkg::KIND_ALLOC: begin
                            if (!table_empty) n_state = nfa_pkg::S_WALK;
                        end
                        nfa_pkg::KIND_DUMP: begin
                            if (!table_empty) n_state = nfa_pkg::S_DUMP;
                        end
                        default: n_state = nfa_pkg::S_IDLE;
                    endcase
                end
            end
            nfa_pkg::S_FIND: begin
                if (r_free[r_scan]) begin
                    n_state = table_empty ? nfa_pkg::S_IDLE : nfa_pkg::S_LINK;
                end
            end
            nfa_pkg::S_LINK: n_state = nfa_pkg::S_IDLE;
            nfa_pkg::S_WALK: begin
                if (fit || walk_end) n_state = nfa_pkg::S_IDLE;
            end
            nfa_pkg::S_DUMP: begin
                if (dump_last) n_state = nfa_pkg::S_IDLE;
            end
            default: n_state = nfa_pkg::S_IDLE;
        endcase
    end

    // Datapath, table access and result words
    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        n_pred   = r_pred;
        n_free   = r_free;
        n_cur    = r_cur;
        n_prev   = r_prev;
        n_scan   = r_scan;
        n_k      = r_k;
        n_item   = r_item;
        n_result = r_result;
        n_strobe = 1'b0;

        rd_slot_en   = 1'b0;
        rd_slot      = r_cur;
        wr_addr_en   = 1'b0;
        wr_size_en   = 1'b0;
        wr_link_en   = 1'b0;
        wr_addr_slot = r_scan;
        wr_size_slot = r_scan;
        wr_link_slot = r_scan;
        wr_addr_data = held_addr_m;
        wr_size_data = r_item.block_size;
        wr_link_data = r_cursor;

        case (r_state)
            nfa_pkg::S_IDLE: begin
                if (accept) begin
                    // Latch the word and start reading the cursor entry
                    n_item     = i_item;
                    n_k        = '0;
                    n_scan     = '0;
                    n_cur      = r_cursor;
                    n_prev     = r_pred;
                    rd_slot_en = 1'b1;
                    rd_slot    = r_cursor;
                    case (i_item.kind)
                        nfa_pkg::KIND_ADD: begin
                            if (table_full) begin
                                n_strobe = 1'b1;
                                n_result = make_result(nfa_pkg::STATUS_FULL,
                                    FW'(in_addr_m), i_item.block_size, 1'b1);
                            end
                        end
                        nfa_pkg::KIND_ALLOC: begin
                            if (table_empty) begin
                                n_strobe = 1'b1;
                                n_result = make_result(nfa_pkg::STATUS_NOFIT,
                                    '0, '0, 1'b1);
                            end
                        end
                        nfa_pkg::KIND_DUMP: begin
                            if (table_empty) begin
                                n_strobe = 1'b1;
                                n_result = make_result(nfa_pkg::STATUS_DONE,
                                    '0, '0, 1'b1);
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_result = make_result(nfa_pkg::STATUS_DONE, '0, '0, 1'b1);
                        end
                    endcase
                end
            end

            nfa_pkg::S_FIND: begin
                if (r_free[r_scan]) begin
                    // Fill the new entry; its successor is the cursor, or itself in an empty table
                    wr_addr_en   = 1'b1;
                    wr_size_en   = 1'b1;
                    wr_link_en   = 1'b1;
                    wr_link_data = table_empty ? r_scan : r_cursor;
                    n_cur        = r_scan;
                    if (table_empty) begin
                        n_free[r_scan] = 1'b0;
                        n_count        = CW'(1);
                        n_cursor       = r_scan;
                        n_pred         = r_scan;
                        n_strobe       = 1'b1;
                        n_result       = make_result(nfa_pkg::STATUS_DONE,
                            FW'(held_addr_m), r_item.block_size, 1'b1);
                    end
                end else begin
                    n_scan = r_scan + SW'(1);
                end
            end

            nfa_pkg::S_LINK: begin
                // Hook the new entry in behind the old tail
                wr_link_en    = 1'b1;
                wr_link_slot  = r_pred;
                wr_link_data  = r_cur;
                n_free[r_cur] = 1'b0;
                n_count       = r_count + CW'(1);
                n_pred        = r_cur;
                n_strobe      = 1'b1;
                n_result      = make_result(nfa_pkg::STATUS_DONE,
                    FW'(held_addr_m), r_item.block_size, 1'b1);
            end

            nfa_pkg::S_WALK: begin
                if (fit) begin
                    n_strobe = 1'b1;
                    if (exact) begin
                        // Unlink the entry and move the cursor past it
                        n_free[r_cur] = 1'b1;
                        n_count       = r_count - CW'(1);
                        if (r_count == CW'(1)) begin
                            n_cursor = '0;
                            n_pred   = '0;
                        end else begin
                            wr_link_en   = 1'b1;
                            wr_link_slot = r_prev;
                            wr_link_data = r_rd_link;
                            n_cursor     = r_rd_link;
                            n_pred       = r_prev;
                        end
                        n_result = make_result(nfa_pkg::STATUS_DONE,
                            FW'(r_rd_addr), '0, 1'b1);
                    end else begin
                        // Shrink in place, cursor stays on this entry
                        wr_size_en   = 1'b1;
                        wr_size_slot = r_cur;
                        wr_size_data = remain;
                        n_cursor     = r_cur;
                        n_pred       = r_prev;
                        n_result     = make_result(nfa_pkg::STATUS_DONE,
                            FW'(r_rd_addr), remain, 1'b1);
                    end
                end else if (walk_end) begin
                    n_strobe = 1'b1;
                    n_result = make_result(nfa_pkg::STATUS_NOFIT, '0, '0, 1'b1);
                end else begin
                    // Advance to the successor
                    n_k        = k_inc;
                    n_prev     = r_cur;
                    n_cur      = r_rd_link;
                    rd_slot_en = 1'b1;
                    rd_slot    = r_rd_link;
                end
            end

            nfa_pkg::S_DUMP: begin
                n_strobe   = 1'b1;
                n_result   = make_result(nfa_pkg::STATUS_ENTRY,
                    FW'(r_rd_addr), r_rd_size, dump_last);
                n_k        = k_inc;
                n_cur      = r_rd_link;
                rd_slot_en = 1'b1;
                rd_slot    = r_rd_link;
            end

            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // Table memories
    always_ff @(posedge i_clk) begin
        if (wr_addr_en) begin
            mem_addr[wr_addr_slot] <= wr_addr_data;
        end
        if (wr_size_en) begin
            mem_size[wr_size_slot] <= wr_size_data;
        end
        if (wr_link_en) begin
            mem_link[wr_link_slot] <= wr_link_data;
        end
        if (rd_slot_en) begin
            r_rd_addr <= mem_addr[rd_slot];
            r_rd_size <= mem_size[rd_slot];
            r_rd_link <= mem_link[rd_slot];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_result <= n_result;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_scan   <= n_scan;
        r_k      <= n_k;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nfa_pkg::S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_pred   <= '0;
            r_free   <= '1;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_pred   <= n_pred;
            r_free   <= n_free;
            r_strobe <= n_strobe;
        end
    end

    // Every slot is either free or counted in the list
    `ASSERT_NEVER(a_slot_balance, ($countones(r_free) + int'(r_count)) != MAX_BLOCKS, "slot map and block count disagree")

    // A taken word either answers at once or keeps the block busy
    `ASSERT_NEXT(a_accept_progress, accept, o_busy || o_strobe, "accepted word neither answered nor in progress")

    // Table-full status only with every slot in use
    `ASSERT_IMPLIES(a_full_status, o_strobe && (o_result.status == nfa_pkg::STATUS_FULL), table_full, "table-full reported with free slots")

    // Block count stays within the table
    `ASSERT_NEVER(a_count_range, int'(r_count) > MAX_BLOCKS, "block count beyond table size")

endmodule

`default_nettype wire
